@@ hdl/kps_pkg.sv @@
// Shared types and constants for the 2x2 keypad scanner.
// Used by kps_cfg, kps_core and keypad_2x2_scan_press_detect; no dependencies.
`timescale 1ns / 1ps

package kps_pkg;

    localparam int unsigned PERIOD_W = 8;
    localparam int unsigned POLLS_W  = 16;
    localparam int unsigned CODE_W   = 3;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned IN_W     = 8;
    localparam int unsigned OUT_W    = 16;

    localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RESET = 8'd30;
    localparam logic [POLLS_W-1:0]  LONG_POLLS_RESET  = 16'd1000;
    localparam logic [PERIOD_W-1:0] ELAPSED_MAX       = 8'd255;

    // Key codes
    localparam logic [CODE_W-1:0] CODE_NONE  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_RB_CA = 3'd1;
    localparam logic [CODE_W-1:0] CODE_RB_CB = 3'd2;
    localparam logic [CODE_W-1:0] CODE_RA_CA = 3'd3;
    localparam logic [CODE_W-1:0] CODE_RA_CB = 3'd4;

    // Register select, taken from paddr[2]
    localparam logic REG_SCAN_PERIOD = 1'b0;
    localparam logic REG_LONG_POLLS  = 1'b1;

    typedef struct packed {
        logic [PERIOD_W-1:0] scan_period_ms;
        logic [POLLS_W-1:0]  long_press_polls;
    } cfg_t;

    typedef struct packed {
        logic ms_tick;
        logic row_a_level;
        logic row_b_level;
    } poll_t;

    typedef struct packed {
        logic              column_a_drive;
        logic [CODE_W-1:0] key_code;
        logic [CODE_W-1:0] pressed_once;
        logic [CODE_W-1:0] long_press_key;
    } result_t;

endpackage

@@ hdl/kps_cfg.sv @@
// APB-style configuration registers for the keypad scanner.
// Depends on kps_pkg.
`timescale 1ns / 1ps

module kps_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kps_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output kps_pkg::cfg_t              cfg
);

    logic [kps_pkg::PERIOD_W-1:0] scan_period_reg;
    logic [kps_pkg::PERIOD_W-1:0] scan_period_next;
    logic [kps_pkg::POLLS_W-1:0]  long_polls_reg;
    logic [kps_pkg::POLLS_W-1:0]  long_polls_next;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        scan_period_next = scan_period_reg;
        long_polls_next  = long_polls_reg;
        if (wr_en)
        begin
            case (paddr[2])
                kps_pkg::REG_SCAN_PERIOD: scan_period_next = pwdata[kps_pkg::PERIOD_W-1:0];
                kps_pkg::REG_LONG_POLLS:  long_polls_next  = pwdata[kps_pkg::POLLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period_reg <= kps_pkg::SCAN_PERIOD_RESET;
            long_polls_reg  <= kps_pkg::LONG_POLLS_RESET;
        end
        else
        begin
            scan_period_reg <= scan_period_next;
            long_polls_reg  <= long_polls_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            kps_pkg::REG_SCAN_PERIOD: prdata = {24'd0, scan_period_reg};
            kps_pkg::REG_LONG_POLLS:  prdata = {16'd0, long_polls_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg.scan_period_ms   = scan_period_reg;
    assign cfg.long_press_polls = long_polls_reg;

endmodule

@@ hdl/kps_core.sv @@
// Per-poll scan and press-detect logic with its state registers.
// Depends on kps_pkg.
`timescale 1ns / 1ps

module kps_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  kps_pkg::poll_t   poll,
    input  kps_pkg::cfg_t    cfg,
    output kps_pkg::result_t result
);

    logic [kps_pkg::PERIOD_W-1:0] elapsed_reg, elapsed_next;
    logic [kps_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [kps_pkg::CODE_W-1:0]   held_key_reg, held_key_next;
    logic                         press_latched_reg, press_latched_next;
    logic [kps_pkg::POLLS_W-1:0]  hold_count_reg, hold_count_next;
    logic [kps_pkg::CODE_W-1:0]   long_key_reg, long_key_next;

    logic [kps_pkg::PERIOD_W-1:0] elapsed_inc;
    logic [kps_pkg::POLLS_W-1:0]  hold_inc;
    logic [kps_pkg::CODE_W-1:0]   once;
    logic                         col_a;

    always_comb
    begin
        col_a = (phase_reg[1] == 1'b0);

        // Saturating millisecond count
        if (poll.ms_tick && (elapsed_reg != kps_pkg::ELAPSED_MAX))
            elapsed_inc = elapsed_reg + 1'b1;
        else
            elapsed_inc = elapsed_reg;

        elapsed_next  = elapsed_inc;
        phase_next    = phase_reg;
        held_key_next = held_key_reg;

        if (elapsed_inc >= cfg.scan_period_ms)
        begin
            elapsed_next = '0;
            if (!poll.row_a_level)
                held_key_next = col_a ? kps_pkg::CODE_RA_CA : kps_pkg::CODE_RA_CB;
            else if (!poll.row_b_level)
                held_key_next = col_a ? kps_pkg::CODE_RB_CA : kps_pkg::CODE_RB_CB;
            else
            begin
                held_key_next = kps_pkg::CODE_NONE;
                phase_next    = phase_reg + 1'b1;
            end
        end

        once               = kps_pkg::CODE_NONE;
        hold_inc           = hold_count_reg + 1'b1;
        press_latched_next = press_latched_reg;
        hold_count_next    = hold_count_reg;
        long_key_next      = long_key_reg;

        if (held_key_next != kps_pkg::CODE_NONE)
        begin
            if (!press_latched_reg)
            begin
                press_latched_next = 1'b1;
                once               = held_key_next;
            end
            hold_count_next = hold_inc;
            if (hold_inc == cfg.long_press_polls)
            begin
                long_key_next   = held_key_next;
                hold_count_next = '0;
            end
        end
        else
        begin
            press_latched_next = 1'b0;
            hold_count_next    = '0;
            long_key_next      = kps_pkg::CODE_NONE;
        end

        result.column_a_drive = col_a;
        result.key_code       = held_key_next;
        result.pressed_once   = once;
        result.long_press_key = long_key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg       <= '0;
            phase_reg         <= '0;
            held_key_reg      <= kps_pkg::CODE_NONE;
            press_latched_reg <= 1'b0;
            hold_count_reg    <= '0;
            long_key_reg      <= kps_pkg::CODE_NONE;
        end
        else if (step_en)
        begin
            elapsed_reg       <= elapsed_next;
            phase_reg         <= phase_next;
            held_key_reg      <= held_key_next;
            press_latched_reg <= press_latched_next;
            hold_count_reg    <= hold_count_next;
            long_key_reg      <= long_key_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The latch flag tracks whether a key is held
    a_latch_tracks_key: assert property (@(posedge clk) disable iff (!rst_n)
        press_latched_reg == (held_key_reg != kps_pkg::CODE_NONE))
        else $error("press latch out of step with held key");

    // A long-press code only stands while some key is held
    a_long_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        (long_key_reg != kps_pkg::CODE_NONE) |-> (held_key_reg != kps_pkg::CODE_NONE))
        else $error("long-press code without a held key");

    // The phase advances only on an empty sample
    a_phase_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && (phase_next != phase_reg)) |-> (held_key_next == kps_pkg::CODE_NONE))
        else $error("scan phase advanced while a key was sampled");

    // The one-shot code fires only on a press edge
    a_once_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && (once != kps_pkg::CODE_NONE)) |=> press_latched_reg)
        else $error("one-shot code without press latch");
`endif

endmodule

@@ hdl/keypad_2x2_scan_press_detect.sv @@
// Path: a poll beat is held in the input register, its result in the result register.
// Throughput: one poll per cycle; input register, single-pass scan logic, result register.
// A waiting result holds intake only once the input register also holds a beat.
// Reset: rst_n asynchronous, active low; clears all scan state, empties both stages,
// and loads scan_period_ms = 30 and long_press_polls = 1000.
// Depends on kps_pkg, kps_cfg and kps_core.
`timescale 1ns / 1ps

module keypad_2x2_scan_press_detect
(
    input  logic                      clk,
    input  logic                      rst_n,

    // Poll beats
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [kps_pkg::IN_W-1:0]  s_axis_tdata,  // [0] ms_tick, [1] row_a_level,
                                                     // [2] row_b_level, rest zero

    // Result beats
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [kps_pkg::OUT_W-1:0] m_axis_tdata,  // [0] column_a_drive, [3:1] key_code,
                                                     // [6:4] pressed_once,
                                                     // [9:7] long_press_key, rest zero

    // Configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [kps_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    kps_pkg::cfg_t    cfg;
    kps_pkg::poll_t   poll_reg, poll_next;
    kps_pkg::result_t result;
    kps_pkg::result_t result_reg, result_next;

    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;
    logic in_fire;
    logic step_en;

    // The result stage can take a new beat when empty or when its beat leaves now
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    kps_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kps_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .poll    (poll_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Input stage: load on accept, drop when the poll moves on, else hold
    always_comb
    begin
        poll_next = poll_reg;
        if (in_fire)
        begin
            poll_next.ms_tick     = s_axis_tdata[0];
            poll_next.row_a_level = s_axis_tdata[1];
            poll_next.row_b_level = s_axis_tdata[2];
            in_valid_next         = 1'b1;
        end
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    // Result stage: capture when the core steps, drop when taken
    always_comb
    begin
        result_next = result_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
            if (in_valid_reg)
                result_next = result;
        end
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        poll_reg   <= poll_next;
        result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0,
                            result_reg.long_press_key,
                            result_reg.pressed_once,
                            result_reg.key_code,
                            result_reg.column_a_drive};

endmodule
